FILE: rtl/core/gdad_pkg.sv
package gdad_pkg;

   // field widths
   localparam int YEAR_W     = 12;
   localparam int YEAR_CNT_W = YEAR_W + 1;  // room for the year past the last one
   localparam int MONTH_W    = 4;
   localparam int DAY_W      = 5;
   localparam int DELTA_W    = 18;
   localparam int DIFF_W     = 18;
   localparam int YDAYS_W    = 9;

   // calendar constants
   localparam int BASE_YEAR     = 1900;
   localparam int DEF_LAST_YEAR = 2100;
   localparam int MONTHS        = 12;
   localparam int LEAP_DAYS     = 366;
   localparam int PLAIN_DAYS    = 365;
   localparam int CENTURY       = 100;
   localparam int QUAD_CENTURY  = 400;
   localparam int BASE_MOD400   = BASE_YEAR % QUAD_CENTURY;
   localparam int BASE_MOD100   = BASE_YEAR % CENTURY;
   localparam int BASE_MOD4     = BASE_YEAR % 4;
   localparam int DIFF_MAX      = 131071;
   localparam int DIFF_MIN      = -131072;

   typedef enum logic [1:0] {
      ST_OK       = 2'd0,
      ST_BAD_DATE = 2'd1,
      ST_RANGE    = 2'd2
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_START,
      S_YEARS,
      S_MONTHS,
      S_DAY,
      S_DELTA,
      S_BACK_INIT,
      S_BACK_YEARS,
      S_BACK_MONTHS,
      S_DIFF,
      S_SAT,
      S_OUT
   } state_type;

   // year tracker control and status
   typedef struct packed {
      logic init;
      logic step;
   } year_ctl_type;

   typedef struct packed {
      logic [YEAR_CNT_W-1:0] year;
      logic                  leap;
   } year_stat_type;

   // length of a month, 0 for a month code outside 1..12
   function automatic logic [DAY_W-1:0] month_days(input logic [MONTH_W-1:0] m,
                                                   input logic leap);
      logic [DAY_W-1:0] len;
      case (m)
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
         4'd2:                                        len = leap ? 5'd29 : 5'd28;
         default:                                     len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

FILE: rtl/core/gregorian_date_add_days_unit.sv
// A malformed date ends the item early, as soon as the check that finds it fails.
// The year loop walks one year per cycle through a single shared adder, so the block
//   takes one item at a time; the next item is taken the cycle after the result is queued.
// Synchronous active-high reset clears the sequencer and the result valid flag.
module gregorian_date_add_days_unit
   import gdad_pkg::*;
#(
   parameter int LAST_YEAR = DEF_LAST_YEAR
)(
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic                      req_op,
   input  logic [YEAR_W-1:0]         req_year,
   input  logic [MONTH_W-1:0]        req_month,
   input  logic [DAY_W-1:0]          req_day,
   input  logic signed [DELTA_W-1:0] req_delta,
   input  logic [YEAR_W-1:0]         req_other_year,
   input  logic [MONTH_W-1:0]        req_other_month,
   input  logic [DAY_W-1:0]          req_other_day,
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [YEAR_W-1:0]         rsp_res_year,
   output logic [MONTH_W-1:0]        rsp_res_month,
   output logic [DAY_W-1:0]          rsp_res_day,
   output logic signed [DIFF_W-1:0]  rsp_day_difference
);

   // accumulator wide enough for a day count plus or minus a delta
   localparam int SpanDays = (LAST_YEAR - BASE_YEAR + 1) * LEAP_DAYS;
   localparam int SpanW    = $clog2(SpanDays + 1);
   localparam int CntW     = ((SpanW > DELTA_W - 1) ? SpanW : DELTA_W - 1) + 2;

   state_type                 state_ff, state_in;
   logic signed [CntW-1:0]    acc_ff, acc_in;
   logic signed [CntW-1:0]    dn0_ff, dn0_in;
   logic                      pass_ff, pass_in;
   logic [MONTH_W-1:0]        cm_ff, cm_in;
   status_type                st_ff, st_in;

   logic                      op_ff;
   logic [YEAR_W-1:0]         y_ff, oy_ff;
   logic [MONTH_W-1:0]        m_ff, om_ff;
   logic [DAY_W-1:0]          d_ff, od_ff;
   logic signed [DELTA_W-1:0] delta_ff;

   logic                      rsp_valid_ff, rsp_valid_in;
   logic [1:0]                rsp_status_ff, rsp_status_in;
   logic [YEAR_W-1:0]         rsp_year_ff, rsp_year_in;
   logic [MONTH_W-1:0]        rsp_month_ff, rsp_month_in;
   logic [DAY_W-1:0]          rsp_day_ff, rsp_day_in;
   logic signed [DIFF_W-1:0]  rsp_diff_ff, rsp_diff_in;

   year_ctl_type              yctl;
   year_stat_type             ystat;

   logic [YEAR_W-1:0]         ty;
   logic [MONTH_W-1:0]        tm;
   logic [DAY_W-1:0]          td;
   logic [YDAYS_W-1:0]        yd;
   logic [DAY_W-1:0]          md;
   logic                      sub;
   logic signed [CntW-1:0]    opd;
   logic signed [CntW-1:0]    sum;
   logic                      req_take;
   logic                      out_free;

   gdad_year_trk u_year (
      .clock (clock),
      .reset (reset),
      .ctl   (yctl),
      .stat  (ystat)
   );

   // date under conversion: first date, then the other one for a difference
   assign ty = pass_ff ? oy_ff : y_ff;
   assign tm = pass_ff ? om_ff : m_ff;
   assign td = pass_ff ? od_ff : d_ff;

   assign yd = ystat.leap ? YDAYS_W'(LEAP_DAYS) : YDAYS_W'(PLAIN_DAYS);
   assign md = month_days(cm_ff, ystat.leap);

   // the one shared adder
   assign sum = acc_ff + (sub ? ~opd : opd) + CntW'(sub);

   assign req_stall = (state_ff != S_IDLE);
   assign req_take  = req_valid && !req_stall;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // sequencer
   always_comb begin
      state_in      = state_ff;
      acc_in        = acc_ff;
      dn0_in        = dn0_ff;
      pass_in       = pass_ff;
      cm_in         = cm_ff;
      st_in         = st_ff;
      yctl          = '0;
      sub           = 1'b0;
      opd           = '0;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_year_in   = rsp_year_ff;
      rsp_month_in  = rsp_month_ff;
      rsp_day_in    = rsp_day_ff;
      rsp_diff_in   = rsp_diff_ff;

      case (state_ff)
         S_IDLE: begin
            if (req_take) begin
               pass_in  = 1'b0;
               st_in    = ST_OK;
               state_in = S_START;
            end
         end
         S_START: begin
            acc_in    = '0;
            cm_in     = MONTH_W'(1);
            yctl.init = 1'b1;
            if ((ty < YEAR_W'(BASE_YEAR)) || (ty > YEAR_W'(LAST_YEAR)) ||
                (tm == '0) || (tm > MONTH_W'(MONTHS))) begin
               st_in    = ST_BAD_DATE;
               state_in = S_OUT;
            end else begin
               state_in = S_YEARS;
            end
         end
         // whole years from the base year up to the target year
         S_YEARS: begin
            opd = CntW'(yd);
            if (ystat.year == YEAR_CNT_W'(ty)) begin
               state_in = S_MONTHS;
            end else begin
               acc_in    = sum;
               yctl.step = 1'b1;
            end
         end
         // whole months before the target month
         S_MONTHS: begin
            opd = CntW'(md);
            if (cm_ff == tm) begin
               state_in = S_DAY;
            end else begin
               acc_in = sum;
               cm_in  = cm_ff + 1'b1;
            end
         end
         S_DAY: begin
            opd = CntW'(td - 1'b1);
            if ((td == '0) || (td > md)) begin
               st_in    = ST_BAD_DATE;
               state_in = S_OUT;
            end else begin
               acc_in = sum;
               if (!op_ff) begin
                  state_in = S_DELTA;
               end else if (!pass_ff) begin
                  dn0_in   = sum;
                  pass_in  = 1'b1;
                  state_in = S_START;
               end else begin
                  state_in = S_DIFF;
               end
            end
         end
         S_DELTA: begin
            opd      = CntW'(delta_ff);
            acc_in   = sum;
            state_in = S_BACK_INIT;
         end
         S_BACK_INIT: begin
            cm_in     = MONTH_W'(1);
            yctl.init = 1'b1;
            if (acc_ff[CntW-1]) begin
               st_in    = ST_RANGE;
               state_in = S_OUT;
            end else begin
               state_in = S_BACK_YEARS;
            end
         end
         // peel off whole years while the count covers them
         S_BACK_YEARS: begin
            sub = 1'b1;
            opd = CntW'(yd);
            if (ystat.year > YEAR_CNT_W'(LAST_YEAR)) begin
               st_in    = ST_RANGE;
               state_in = S_OUT;
            end else if (!sum[CntW-1]) begin
               acc_in    = sum;
               yctl.step = 1'b1;
            end else begin
               state_in = S_BACK_MONTHS;
            end
         end
         S_BACK_MONTHS: begin
            sub = 1'b1;
            opd = CntW'(md);
            if ((cm_ff < MONTH_W'(MONTHS)) && !sum[CntW-1]) begin
               acc_in = sum;
               cm_in  = cm_ff + 1'b1;
            end else begin
               state_in = S_OUT;
            end
         end
         S_DIFF: begin
            sub      = 1'b1;
            opd      = dn0_ff;
            acc_in   = sum;
            state_in = S_SAT;
         end
         S_SAT: begin
            if (acc_ff > CntW'(DIFF_MAX)) begin
               acc_in = CntW'(DIFF_MAX);
               st_in  = ST_RANGE;
            end else if (acc_ff < CntW'(DIFF_MIN)) begin
               acc_in = CntW'(DIFF_MIN);
               st_in  = ST_RANGE;
            end
            state_in = S_OUT;
         end
         // hand the item to the result register once it is free
         S_OUT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = st_ff;
               rsp_year_in   = '0;
               rsp_month_in  = '0;
               rsp_day_in    = '0;
               rsp_diff_in   = '0;
               if (st_ff == ST_OK && !op_ff) begin
                  rsp_year_in  = ystat.year[YEAR_W-1:0];
                  rsp_month_in = cm_ff;
                  rsp_day_in   = acc_ff[DAY_W-1:0] + 1'b1;
               end
               if (op_ff && st_ff != ST_BAD_DATE) begin
                  rsp_diff_in = acc_ff[DIFF_W-1:0];
               end
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
         pass_ff      <= 1'b0;
         st_ff        <= ST_OK;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         pass_ff      <= pass_in;
         st_ff        <= st_in;
      end
   end

   // working and payload registers
   always_ff @(posedge clock) begin
      acc_ff        <= acc_in;
      dn0_ff        <= dn0_in;
      cm_ff         <= cm_in;
      rsp_status_ff <= rsp_status_in;
      rsp_year_ff   <= rsp_year_in;
      rsp_month_ff  <= rsp_month_in;
      rsp_day_ff    <= rsp_day_in;
      rsp_diff_ff   <= rsp_diff_in;
      if (req_take) begin
         op_ff    <= req_op;
         y_ff     <= req_year;
         m_ff     <= req_month;
         d_ff     <= req_day;
         delta_ff <= req_delta;
         oy_ff    <= req_other_year;
         om_ff    <= req_other_month;
         od_ff    <= req_other_day;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_status         = rsp_status_ff;
   assign rsp_res_year       = rsp_year_ff;
   assign rsp_res_month      = rsp_month_ff;
   assign rsp_res_day        = rsp_day_ff;
   assign rsp_day_difference = rsp_diff_ff;

`ifndef SYNTHESIS
   // a new result only comes out of the output state
   a_rsp_from_out: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(state_ff == S_OUT))
      else $error("result raised outside output state");

   // failed items carry no date
   a_err_no_date: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != ST_OK) |->
         (rsp_res_year == '0) && (rsp_res_month == '0) && (rsp_res_day == '0))
      else $error("date fields set on a failed item");

   // a returned date is a real calendar date
   a_date_sane: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == ST_OK) && (rsp_res_month != '0) |->
         (rsp_res_month <= MONTH_W'(MONTHS)) && (rsp_res_day != '0) &&
         (rsp_res_year >= YEAR_W'(BASE_YEAR)))
      else $error("malformed result date");

   // the back conversion never runs past the year after the last one
   a_year_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_BACK_YEARS) |-> (ystat.year <= YEAR_CNT_W'(LAST_YEAR + 1)))
      else $error("year walk overran the range");
`endif

endmodule

FILE: rtl/core/gdad_year_trk.sv
module gdad_year_trk
   import gdad_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  year_ctl_type  ctl,
   output year_stat_type stat
);

   logic [YEAR_CNT_W-1:0] year_ff, year_in;
   logic [1:0]            c4_ff, c4_in;
   logic [6:0]            c100_ff, c100_in;
   logic [8:0]            c400_ff, c400_in;

   // year and its residues mod 4, 100, 400 walk together from the base year
   always_comb begin
      year_in = year_ff;
      c4_in   = c4_ff;
      c100_in = c100_ff;
      c400_in = c400_ff;
      if (ctl.init) begin
         year_in = YEAR_CNT_W'(BASE_YEAR);
         c4_in   = 2'(BASE_MOD4);
         c100_in = 7'(BASE_MOD100);
         c400_in = 9'(BASE_MOD400);
      end else if (ctl.step) begin
         year_in = year_ff + 1'b1;
         c4_in   = c4_ff + 1'b1;
         c100_in = (c100_ff == 7'(CENTURY - 1)) ? '0 : c100_ff + 1'b1;
         c400_in = (c400_ff == 9'(QUAD_CENTURY - 1)) ? '0 : c400_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         year_ff <= YEAR_CNT_W'(BASE_YEAR);
         c4_ff   <= 2'(BASE_MOD4);
         c100_ff <= 7'(BASE_MOD100);
         c400_ff <= 9'(BASE_MOD400);
      end else begin
         year_ff <= year_in;
         c4_ff   <= c4_in;
         c100_ff <= c100_in;
         c400_ff <= c400_in;
      end
   end

   assign stat.year = year_ff;
   assign stat.leap = (c400_ff == '0) || ((c100_ff != '0) && (c4_ff == '0));

endmodule

FILE: tb/sv/tb_gregorian_date_add_days_unit.sv
module tb_gregorian_date_add_days_unit
   import gdad_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int LAST_YEAR   = DEF_LAST_YEAR;
   localparam int N_RANDOM    = 1650;
   localparam int HOLD_CYCLES = 1500;
   localparam int TAIL_CYCLES = 2 * (LAST_YEAR - BASE_YEAR) + 64;
   localparam int MAX_REPORTS = 10;

   // operation codes
   localparam logic OP_ADD  = 1'b0;
   localparam logic OP_DIFF = 1'b1;

   // table rows either carry a literal answer or go through the predictor
   localparam bit LIT  = 1'b1;
   localparam bit CALC = 1'b0;

   localparam int MONTH_LEN [MONTHS] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

   typedef enum int {STALL_NONE, STALL_LIGHT, STALL_HEAVY, STALL_PERIODIC} stall_mode_type;

   typedef struct packed {
      logic                      op;
      logic [YEAR_W-1:0]         year;
      logic [MONTH_W-1:0]        month;
      logic [DAY_W-1:0]          day;
      logic signed [DELTA_W-1:0] delta;
      logic [YEAR_W-1:0]         oyear;
      logic [MONTH_W-1:0]        omonth;
      logic [DAY_W-1:0]          oday;
   } date_req_type;

   typedef struct packed {
      status_type               status;
      logic [YEAR_W-1:0]        year;
      logic [MONTH_W-1:0]       month;
      logic [DAY_W-1:0]         day;
      logic signed [DIFF_W-1:0] diff;
   } date_rsp_type;

   typedef struct {
      date_req_type req;
      bit           lit;
      date_rsp_type rsp;
   } dir_row_type;

   localparam date_rsp_type BAD_RSP   = '{ST_BAD_DATE, '0, '0, '0, '0};
   localparam date_rsp_type RANGE_RSP = '{ST_RANGE, '0, '0, '0, '0};

   localparam int N_DIR = 25;

   // directed items: calendar edges, malformed dates, both operations
   dir_row_type dir_table [N_DIR] = '{
      '{'{OP_ADD, 12'd1900, 4'd1, 5'd1, 18'h00000, 12'd0, 4'd0, 5'd0}, LIT,
        '{ST_OK, 12'd1900, 4'd1, 5'd1, 18'h00000}},
      '{'{OP_ADD, 12'd1900, 4'd1, 5'd1, 18'h3FFFF, 12'd0, 4'd0, 5'd0}, LIT, RANGE_RSP},
      '{'{OP_ADD, 12'd2100, 4'd12, 5'd31, 18'h00000, 12'd0, 4'd0, 5'd0}, LIT,
        '{ST_OK, 12'd2100, 4'd12, 5'd31, 18'h00000}},
      '{'{OP_ADD, 12'd2100, 4'd12, 5'd31, 18'h00001, 12'd0, 4'd0, 5'd0}, LIT, RANGE_RSP},
      '{'{OP_ADD, 12'd1899, 4'd12, 5'd31, 18'h00000, 12'd0, 4'd0, 5'd0}, LIT, BAD_RSP},
      '{'{OP_ADD, 12'd2101, 4'd1, 5'd1, 18'h00000, 12'd0, 4'd0, 5'd0}, LIT, BAD_RSP},
      '{'{OP_ADD, 12'd2000, 4'd0, 5'd10, 18'h00000, 12'd0, 4'd0, 5'd0}, LIT, BAD_RSP},
      '{'{OP_ADD, 12'd2000, 4'd13, 5'd10, 18'h00000, 12'd0, 4'd0, 5'd0}, LIT, BAD_RSP},
      '{'{OP_DIFF, 12'd4095, 4'd15, 5'd31, 18'h20000, 12'd4095, 4'd15, 5'd31}, LIT, BAD_RSP},
      '{'{OP_ADD, 12'd2000, 4'd6, 5'd0, 18'h00000, 12'd0, 4'd0, 5'd0}, LIT, BAD_RSP},
      '{'{OP_ADD, 12'd2001, 4'd4, 5'd31, 18'h00000, 12'd0, 4'd0, 5'd0}, LIT, BAD_RSP},
      '{'{OP_ADD, 12'd1900, 4'd2, 5'd29, 18'h00000, 12'd0, 4'd0, 5'd0}, LIT, BAD_RSP},
      '{'{OP_ADD, 12'd2100, 4'd2, 5'd29, 18'h00000, 12'd0, 4'd0, 5'd0}, LIT, BAD_RSP},
      '{'{OP_ADD, 12'd2000, 4'd2, 5'd29, 18'h00000, 12'd0, 4'd0, 5'd0}, LIT,
        '{ST_OK, 12'd2000, 4'd2, 5'd29, 18'h00000}},
      '{'{OP_ADD, 12'd2004, 4'd2, 5'd28, 18'h00001, 12'd0, 4'd0, 5'd0}, LIT,
        '{ST_OK, 12'd2004, 4'd2, 5'd29, 18'h00000}},
      '{'{OP_ADD, 12'd1900, 4'd1, 5'd1, 18'h1FFFF, 12'd0, 4'd0, 5'd0}, CALC, '0},
      '{'{OP_ADD, 12'd2100, 4'd12, 5'd31, 18'h20000, 12'd0, 4'd0, 5'd0}, LIT, RANGE_RSP},
      '{'{OP_ADD, 12'd1999, 4'd12, 5'd31, 18'h00001, 12'd4095, 4'd15, 5'd31}, CALC, '0},
      '{'{OP_DIFF, 12'd1900, 4'd1, 5'd1, 18'h00000, 12'd1900, 4'd1, 5'd1}, LIT,
        '{ST_OK, 12'd0, 4'd0, 5'd0, 18'h00000}},
      '{'{OP_DIFF, 12'd1900, 4'd1, 5'd1, 18'h1FFFF, 12'd1900, 4'd1, 5'd2}, LIT,
        '{ST_OK, 12'd0, 4'd0, 5'd0, 18'h00001}},
      '{'{OP_DIFF, 12'd2000, 4'd3, 5'd1, 18'h00000, 12'd2000, 4'd0, 5'd1}, LIT, BAD_RSP},
      '{'{OP_DIFF, 12'd2000, 4'd2, 5'd30, 18'h00000, 12'd2000, 4'd3, 5'd1}, LIT, BAD_RSP},
      '{'{OP_DIFF, 12'd1900, 4'd1, 5'd1, 18'h00000, 12'd2100, 4'd12, 5'd31}, CALC, '0},
      '{'{OP_DIFF, 12'd2100, 4'd12, 5'd31, 18'h00000, 12'd1900, 4'd1, 5'd1}, CALC, '0},
      '{'{OP_DIFF, 12'd2024, 4'd3, 5'd1, 18'h00000, 12'd2024, 4'd2, 5'd28}, CALC, '0}
   };

   logic                      clock = 1'b0;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic                      req_op;
   logic [YEAR_W-1:0]         req_year;
   logic [MONTH_W-1:0]        req_month;
   logic [DAY_W-1:0]          req_day;
   logic signed [DELTA_W-1:0] req_delta;
   logic [YEAR_W-1:0]         req_other_year;
   logic [MONTH_W-1:0]        req_other_month;
   logic [DAY_W-1:0]          req_other_day;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [1:0]                rsp_status;
   logic [YEAR_W-1:0]         rsp_res_year;
   logic [MONTH_W-1:0]        rsp_res_month;
   logic [DAY_W-1:0]          rsp_res_day;
   logic signed [DIFF_W-1:0]  rsp_day_difference;

   date_rsp_type pending_answers [$];
   int           mismatches   = 0;
   int           results_seen = 0;
   int           n_add        = 0;
   int           n_diff       = 0;
   int           n_bad_date   = 0;
   int           n_range      = 0;

   gregorian_date_add_days_unit #(
      .LAST_YEAR(LAST_YEAR)
   ) uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_year           (req_year),
      .req_month          (req_month),
      .req_day            (req_day),
      .req_delta          (req_delta),
      .req_other_year     (req_other_year),
      .req_other_month    (req_other_month),
      .req_other_day      (req_other_day),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_status         (rsp_status),
      .rsp_res_year       (rsp_res_year),
      .rsp_res_month      (rsp_res_month),
      .rsp_res_day        (rsp_res_day),
      .rsp_day_difference (rsp_day_difference)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // calendar arithmetic
   function automatic bit is_leap(int y);
      if (y % QUAD_CENTURY == 0) return 1'b1;
      if (y % CENTURY == 0) return 1'b0;
      return (y % 4 == 0);
   endfunction

   function automatic int month_len(int y, int m);
      if (m < 1 || m > MONTHS) return 0;
      return MONTH_LEN[m-1] + ((m == 2 && is_leap(y)) ? 1 : 0);
   endfunction

   function automatic int year_len(int y);
      return is_leap(y) ? LEAP_DAYS : PLAIN_DAYS;
   endfunction

   function automatic bit date_valid(int y, int m, int d);
      if (y < BASE_YEAR || y > LAST_YEAR) return 1'b0;
      if (m < 1 || m > MONTHS) return 1'b0;
      return (d >= 1 && d <= month_len(y, m));
   endfunction

   function automatic int leaps_through(int n);
      return n / 4 - n / CENTURY + n / QUAD_CENTURY;
   endfunction

   // day count from the first day of the base year
   function automatic int days_since_base(int y, int m, int d);
      int total;
      total = PLAIN_DAYS * (y - BASE_YEAR) + leaps_through(y - 1) - leaps_through(BASE_YEAR - 1);
      for (int k = 1; k < m; k++) total += month_len(y, k);
      return total + d - 1;
   endfunction

   // expected answer for one request item
   function automatic date_rsp_type calendar_answer(date_req_type r);
      date_rsp_type a;
      int           total;
      int           cy;
      int           cm;
      int           diff;
      a = '0;
      a.status = ST_OK;
      if (!date_valid(int'(r.year), int'(r.month), int'(r.day))) begin
         a.status = ST_BAD_DATE;
      end else if (r.op == OP_ADD) begin
         total = days_since_base(int'(r.year), int'(r.month), int'(r.day)) + int'(r.delta);
         if (total < 0) begin
            a.status = ST_RANGE;
         end else begin
            cy = BASE_YEAR;
            while (cy <= LAST_YEAR && total >= year_len(cy)) begin
               total -= year_len(cy);
               cy++;
            end
            if (cy > LAST_YEAR) begin
               a.status = ST_RANGE;
            end else begin
               cm = 1;
               while (cm < MONTHS && total >= month_len(cy, cm)) begin
                  total -= month_len(cy, cm);
                  cm++;
               end
               a.year  = YEAR_W'(cy);
               a.month = MONTH_W'(cm);
               a.day   = DAY_W'(total + 1);
            end
         end
      end else if (!date_valid(int'(r.oyear), int'(r.omonth), int'(r.oday))) begin
         a.status = ST_BAD_DATE;
      end else begin
         diff = days_since_base(int'(r.oyear), int'(r.omonth), int'(r.oday))
              - days_since_base(int'(r.year), int'(r.month), int'(r.day));
         if (diff > DIFF_MAX) begin
            diff = DIFF_MAX;
            a.status = ST_RANGE;
         end
         if (diff < DIFF_MIN) begin
            diff = DIFF_MIN;
            a.status = ST_RANGE;
         end
         a.diff = DIFF_W'(diff);
      end
      return a;
   endfunction

   // a legal date, now and then one of the calendar corners
   function automatic void pick_valid_date(output int y, output int m, output int d);
      if ($urandom_range(0, 9) == 0) begin
         case ($urandom_range(0, 3))
            0: begin y = BASE_YEAR; m = 1; d = 1; end
            1: begin y = LAST_YEAR; m = 12; d = 31; end
            2: begin y = 2000; m = 2; d = 29; end
            default: begin y = BASE_YEAR; m = 12; d = 31; end
         endcase
      end else begin
         y = $urandom_range(BASE_YEAR, LAST_YEAR);
         m = $urandom_range(1, MONTHS);
         d = $urandom_range(1, month_len(y, m));
      end
   endfunction

   // mostly well-formed items, some raw noise and some broken dates
   function automatic date_req_type random_date_item();
      date_req_type r;
      int           y, m, d, oy, om, od, len, dv, k;
      r.op     = 1'($urandom());
      r.year   = YEAR_W'($urandom());
      r.month  = MONTH_W'($urandom());
      r.day    = DAY_W'($urandom());
      r.delta  = DELTA_W'($urandom());
      r.oyear  = YEAR_W'($urandom());
      r.omonth = MONTH_W'($urandom());
      r.oday   = DAY_W'($urandom());
      k = $urandom_range(0, 99);
      if (k < 12) return r;
      pick_valid_date(y, m, d);
      len = month_len(y, m);
      if (k < 15) begin
         d = (len == 31 || $urandom_range(0, 1) == 0) ? 0 : $urandom_range(len + 1, 31);
      end else if (k < 17) begin
         m = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(MONTHS + 1, 15);
      end
      r.year  = YEAR_W'(y);
      r.month = MONTH_W'(m);
      r.day   = DAY_W'(d);
      if (r.op == OP_ADD) begin
         case ($urandom_range(0, 9))
            0, 1, 2, 3: dv = $urandom_range(0, 800) - 400;
            4, 5:       dv = $urandom_range(0, 80000) - 40000;
            6, 7:       dv = int'(r.delta);
            default: begin
               // land on or just past either end of the calendar
               dv = $urandom_range(0, 2) - 1;
               if (date_valid(y, m, d)) begin
                  if ($urandom_range(0, 1) == 0) dv -= days_since_base(y, m, d);
                  else dv += days_since_base(LAST_YEAR, 12, 31) - days_since_base(y, m, d);
               end
            end
         endcase
         r.delta = DELTA_W'(dv);
      end else begin
         case ($urandom_range(0, 9))
            0: ;
            1: begin
               r.oyear  = r.year;
               r.omonth = r.month;
               r.oday   = r.day;
            end
            default: begin
               pick_valid_date(oy, om, od);
               r.oyear  = YEAR_W'(oy);
               r.omonth = MONTH_W'(om);
               r.oday   = DAY_W'(od);
            end
         endcase
      end
      return r;
   endfunction

   // present one item and hold it until taken
   task automatic offer_item(input date_req_type r, input bit lit,
                             input date_rsp_type lit_rsp);
      req_valid       <= 1'b1;
      req_op          <= r.op;
      req_year        <= r.year;
      req_month       <= r.month;
      req_day         <= r.day;
      req_delta       <= r.delta;
      req_other_year  <= r.oyear;
      req_other_month <= r.omonth;
      req_other_day   <= r.oday;
      do @(posedge clock); while (req_stall);
      pending_answers.push_back(lit ? lit_rsp : calendar_answer(r));
      if (r.op == OP_ADD) n_add++;
      else n_diff++;
   endtask

   task automatic idle_cycles(input int n);
      if (n > 0) begin
         req_valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (pending_answers.size() != 0) @(posedge clock);
   endtask

   // request side
   initial begin : req_side
      int burst_left;
      int gap;
      reset           <= 1'b1;
      req_valid       <= 1'b0;
      req_op          <= OP_ADD;
      req_year        <= '0;
      req_month       <= '0;
      req_day         <= '0;
      req_delta       <= '0;
      req_other_year  <= '0;
      req_other_month <= '0;
      req_other_day   <= '0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      for (int i = 0; i < N_DIR; i++) begin
         offer_item(dir_table[i].req, dir_table[i].lit, dir_table[i].rsp);
         idle_cycles($urandom_range(0, 3));
      end
      wait_drained();

      burst_left = 0;
      for (int i = 0; i < N_RANDOM; i++) begin
         if (burst_left == 0) begin
            if ($urandom_range(0, 7) == 0) begin
               burst_left = $urandom_range(50, 150);
               gap = 0;
            end else begin
               burst_left = $urandom_range(1, 20);
               gap = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 400)
                                                  : $urandom_range(0, 30);
            end
            idle_cycles(gap);
         end
         burst_left--;
         if (i % 500 == 499) wait_drained();
         offer_item(random_date_item(), CALC, '0);
      end

      wait_drained();
      repeat (TAIL_CYCLES) @(posedge clock);

      $display("Ran %0d add and %0d difference items, %0d directed, %0d results checked",
               n_add, n_diff, N_DIR, results_seen);
      $display("Answers with bad date status: %0d, out of range: %0d, mismatches: %0d",
               n_bad_date, n_range, mismatches);
      if (mismatches == 0 && pending_answers.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

   // result side back-pressure, with two long hold-offs
   initial begin : rsp_side
      int             hold_at [2];
      int             hold_idx;
      int             span;
      int             period;
      int             phase;
      stall_mode_type mode;
      hold_at  = '{40, 800};
      hold_idx = 0;
      span     = 0;
      period   = 2;
      phase    = 0;
      mode     = STALL_NONE;
      rsp_stall <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_idx < 2 && results_seen >= hold_at[hold_idx]) begin
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_idx++;
         end
         if (span == 0) begin
            mode   = stall_mode_type'($urandom_range(0, 3));
            span   = $urandom_range(32, 400);
            period = $urandom_range(2, 9);
         end
         span--;
         phase++;
         case (mode)
            STALL_NONE:  rsp_stall <= 1'b0;
            STALL_LIGHT: rsp_stall <= ($urandom_range(0, 3) == 0);
            STALL_HEAVY: rsp_stall <= ($urandom_range(0, 3) != 0);
            default:     rsp_stall <= ((phase % period) < (period / 2));
         endcase
      end
   end

   // compare each taken result with the oldest pending answer
   always @(posedge clock) begin : rsp_check
      date_rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         results_seen++;
         if (rsp_status == ST_BAD_DATE) n_bad_date++;
         if (rsp_status == ST_RANGE) n_range++;
         if (pending_answers.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("%0t: result with nothing pending: status %0d date %0d-%0d-%0d diff %0d",
                        $realtime, rsp_status, rsp_res_year, rsp_res_month, rsp_res_day,
                        rsp_day_difference);
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.status || rsp_res_year !== want.year ||
                rsp_res_month !== want.month || rsp_res_day !== want.day ||
                rsp_day_difference !== want.diff) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display("%0t: mismatch exp %0d %0d-%0d-%0d %0d got %0d %0d-%0d-%0d %0d",
                           $realtime, want.status, want.year, want.month, want.day, want.diff,
                           rsp_status, rsp_res_year, rsp_res_month, rsp_res_day,
                           rsp_day_difference);
            end
         end
      end
   end

   // overall time limit
   initial begin : watchdog
      #50_000_000;
      $display("Timed out with %0d answers still pending", pending_answers.size());
      $display("Regression FAIL");
      $finish;
   end

endmodule

FILE: gregorian_date_add_days_unit.f
rtl/core/gdad_pkg.sv
rtl/core/gdad_year_trk.sv
rtl/core/gregorian_date_add_days_unit.sv
tb/sv/tb_gregorian_date_add_days_unit.sv
